FILE: rtl/chd_pkg.sv
package chd_pkg;

  // Width of a chunk size; a size line holds at most SIZE_BITS/4 hex digits.
  localparam int SIZE_BITS  = 32;
  localparam int MAX_DIGITS = SIZE_BITS / 4;
  localparam int DIGIT_W    = $clog2(MAX_DIGITS + 1);

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;
  localparam logic [7:0] CHAR_UA   = 8'h41;
  localparam logic [7:0] CHAR_UF   = 8'h46;
  localparam logic [7:0] CHAR_LA   = 8'h61;
  localparam logic [7:0] CHAR_LFH  = 8'h66;

  typedef enum logic [2:0] {
    PH_SIZE = 3'd0,
    PH_EXT  = 3'd1,
    PH_DATA = 3'd2,
    PH_CR   = 3'd3,
    PH_LF   = 3'd4,
    PH_DONE = 3'd5,
    PH_ERR  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_DATA = 3'd1,
    KIND_SIZE = 3'd2,
    KIND_DONE = 3'd3,
    KIND_ERR  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] chunk_size;
  } out_item_t;

  typedef struct packed {
    phase_t                 phase;
    logic [SIZE_BITS-1:0]   remaining;
    logic [DIGIT_W-1:0]     digit_count;
    logic                   final_chunk;
  } dec_state_t;

endpackage

FILE: rtl/chd_step.sv
module chd_step (
  input  chd_pkg::dec_state_t cur,
  input  chd_pkg::in_item_t   item,
  output chd_pkg::dec_state_t nxt,
  output chd_pkg::out_item_t  res
);

  chd_pkg::dec_state_t           st;
  logic [7:0]                    c;
  logic                          hex_ok;
  logic [3:0]                    hex_val;
  logic [chd_pkg::SIZE_BITS-1:0] rem_dec;

  // restart applies before the byte is handled
  always_comb begin
    if (item.restart) begin
      st.phase       = chd_pkg::PH_SIZE;
      st.remaining   = '0;
      st.digit_count = '0;
      st.final_chunk = 1'b0;
    end else begin
      st = cur;
    end
  end

  assign c       = item.in_byte;
  assign rem_dec = st.remaining - chd_pkg::SIZE_BITS'(1);

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = '0;
    if (c >= chd_pkg::CHAR_0 && c <= chd_pkg::CHAR_9) begin
      hex_val = 4'(c - chd_pkg::CHAR_0);
    end else if (c >= chd_pkg::CHAR_UA && c <= chd_pkg::CHAR_UF) begin
      hex_val = 4'(c - chd_pkg::CHAR_UA + 8'd10);
    end else if (c >= chd_pkg::CHAR_LA && c <= chd_pkg::CHAR_LFH) begin
      hex_val = 4'(c - chd_pkg::CHAR_LA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // next state
  always_comb begin
    nxt = st;
    case (st.phase)
      chd_pkg::PH_SIZE, chd_pkg::PH_EXT: begin
        if (c == chd_pkg::CHAR_LF) begin
          nxt.digit_count = '0;
          if (st.remaining == '0) begin
            nxt.final_chunk = 1'b1;
            nxt.phase       = chd_pkg::PH_CR;
          end else begin
            nxt.phase = chd_pkg::PH_DATA;
          end
        end else if (st.phase == chd_pkg::PH_SIZE) begin
          if (c == chd_pkg::CHAR_SEMI) begin
            nxt.phase = chd_pkg::PH_EXT;
          end else if (hex_ok) begin
            if (st.digit_count >= chd_pkg::DIGIT_W'(chd_pkg::MAX_DIGITS)) begin
              nxt.phase = chd_pkg::PH_ERR;
            end else begin
              nxt.remaining   = {st.remaining[chd_pkg::SIZE_BITS-5:0], hex_val};
              nxt.digit_count = st.digit_count + chd_pkg::DIGIT_W'(1);
            end
          end
        end
      end
      chd_pkg::PH_DATA: begin
        nxt.remaining = rem_dec;
        if (rem_dec == '0) begin
          nxt.phase = chd_pkg::PH_CR;
        end
      end
      chd_pkg::PH_CR: begin
        nxt.phase = (c == chd_pkg::CHAR_CR) ? chd_pkg::PH_LF : chd_pkg::PH_ERR;
      end
      chd_pkg::PH_LF: begin
        if (c != chd_pkg::CHAR_LF) begin
          nxt.phase = chd_pkg::PH_ERR;
        end else if (st.final_chunk) begin
          nxt.phase = chd_pkg::PH_DONE;
        end else begin
          nxt.phase       = chd_pkg::PH_SIZE;
          nxt.remaining   = '0;
          nxt.digit_count = '0;
          nxt.final_chunk = 1'b0;
        end
      end
      chd_pkg::PH_DONE: begin
        nxt = st;
      end
      default: begin
        nxt.phase = chd_pkg::PH_ERR;
      end
    endcase
  end

  // result beat
  always_comb begin
    res.kind       = chd_pkg::KIND_NONE;
    res.data_byte  = '0;
    res.chunk_size = '0;
    case (st.phase)
      chd_pkg::PH_SIZE, chd_pkg::PH_EXT: begin
        if (c == chd_pkg::CHAR_LF) begin
          res.kind       = chd_pkg::KIND_SIZE;
          res.chunk_size = 32'(st.remaining);
        end else if (st.phase == chd_pkg::PH_SIZE && c != chd_pkg::CHAR_SEMI &&
                     hex_ok &&
                     st.digit_count >= chd_pkg::DIGIT_W'(chd_pkg::MAX_DIGITS)) begin
          res.kind = chd_pkg::KIND_ERR;
        end
      end
      chd_pkg::PH_DATA: begin
        res.kind      = chd_pkg::KIND_DATA;
        res.data_byte = c;
      end
      chd_pkg::PH_CR: begin
        if (c != chd_pkg::CHAR_CR) begin
          res.kind = chd_pkg::KIND_ERR;
        end
      end
      chd_pkg::PH_LF: begin
        if (c != chd_pkg::CHAR_LF) begin
          res.kind = chd_pkg::KIND_ERR;
        end else if (st.final_chunk) begin
          res.kind = chd_pkg::KIND_DONE;
        end
      end
      chd_pkg::PH_DONE: begin
        res.kind = chd_pkg::KIND_NONE;
      end
      default: begin
        res.kind = chd_pkg::KIND_ERR;
      end
    endcase
  end

endmodule

FILE: rtl/chd_obuf.sv
module chd_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  chd_pkg::out_item_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output chd_pkg::out_item_t out_data
);

  logic               main_valid_r, main_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  chd_pkg::out_item_t main_r, main_nxt;
  chd_pkg::out_item_t skid_r, skid_nxt;
  logic               pop;

  assign pop = main_valid_r && !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (push) begin
      // push only happens with the skid empty
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

FILE: rtl/http_chunked_body_decoder.sv
// HTTP/1.1 chunked body decoder, one raw body byte per beat.
// Input channel (in_valid / in_stall / in_data): each beat carries one byte
// and a restart flag; restart clears the decoder before that byte is used.
// Output channel (out_valid / out_stall / out_data): exactly one result beat
// per input beat, in order: nothing, data byte, chunk size done, body
// complete, or format error (sticky until restart).
// The result of a byte is registered in the output register, or in the skid
// register when the output is held. One byte per cycle while in_stall is low,
// set by the single decode step between parser state and output registers.
// Reset (rst_n low, synchronous) returns the parser to the start of a size
// line and empties the output buffer.
// Receiver stall: the output register holds its beat; one further result is
// parked in a skid register, and in_stall rises (registered) only while that
// skid register is occupied, so in_stall never depends on out_stall
// combinationally.
module http_chunked_body_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  chd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output chd_pkg::out_item_t out_data
);

  chd_pkg::dec_state_t state_r;
  chd_pkg::dec_state_t state_nxt;
  chd_pkg::out_item_t  result;
  logic                accept;
  logic                buf_full;

  // a beat is taken whenever the skid slot is free
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  // decode step: parser state plus byte in, next state and result beat out
  chd_step u_step (
    .cur  (state_r),
    .item (in_data),
    .nxt  (state_nxt),
    .res  (result)
  );

  // parser state moves only on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= chd_pkg::PH_SIZE;
      state_r.remaining   <= '0;
      state_r.digit_count <= '0;
      state_r.final_chunk <= 1'b0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // output register with skid slot
  chd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/chd_checker.sv
module chd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input chd_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input chd_pkg::out_item_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // a new result only follows an accepted byte
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result beat without input beat");

  // input back-pressure only after the output was held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("in_stall without output stall");

  // reset empties the output
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("output not empty after reset");

endmodule

bind http_chunked_body_decoder chd_checker u_chd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
